// ===== rtl/core/tpm_pkg.sv =====
// shared constants and types of the triangle perimeter maximum finder
package tpm_pkg;

   localparam int POINT_SLOTS = 16;
   localparam int COORD_BITS  = 16;
   localparam int SLOT_BITS   = $clog2(POINT_SLOTS);
   localparam int PT_BITS     = 3 * COORD_BITS;
   localparam int SQ_BITS     = 2 * COORD_BITS;
   localparam int ACC_BITS    = SQ_BITS + 2;
   localparam int FRAC_SHIFT  = 16;
   localparam int RAD_BITS    = ACC_BITS + FRAC_SHIFT;
   localparam int ROOT_BITS   = RAD_BITS / 2;
   localparam int PSUM_BITS   = ROOT_BITS + 2;
   localparam int PER_BITS    = 27;
   localparam int NUM_BITS    = 8;
   localparam logic [PER_BITS-1:0] SUM_MAX = 27'h7FF_FFFF;

   localparam logic ACT_POINT    = 1'b0;
   localparam logic ACT_TRIANGLE = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH_A,
      S_FETCH_B,
      S_FETCH_C,
      S_LOAD_C,
      S_MUL,
      S_ACC,
      S_ROOT,
      S_WAIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                 done;
      logic [ROOT_BITS-1:0] root;
   } root_res_type;

endpackage

// ===== rtl/core/tpm_sqrt.sv =====
// iterative integer square root, one root bit per cycle
module tpm_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tpm_pkg::RAD_BITS-1:0]  radicand,
   output tpm_pkg::root_res_type         result
);

   localparam int RB       = tpm_pkg::ROOT_BITS;
   localparam int REM_BITS = RB + 3;
   localparam int CNT_BITS = $clog2(RB + 1);

   logic [tpm_pkg::RAD_BITS-1:0] rad_ff, rad_in;
   logic [REM_BITS-1:0]          rem_ff, rem_in;
   logic [RB-1:0]                root_ff, root_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic                         running_ff, running_in;
   logic                         done_ff, done_in;

   logic [REM_BITS-1:0] rem_sh;
   logic [REM_BITS-1:0] trial;
   logic                fits;

   assign rem_sh = {rem_ff[REM_BITS-3:0], rad_ff[tpm_pkg::RAD_BITS-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_comb begin
      rad_in     = rad_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      count_in   = count_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (start) begin
         rad_in     = radicand;
         rem_in     = '0;
         root_in    = '0;
         count_in   = CNT_BITS'(RB);
         running_in = 1'b1;
      end else if (running_ff) begin
         rad_in   = {rad_ff[tpm_pkg::RAD_BITS-3:0], 2'b00};
         rem_in   = fits ? rem_sh - trial : rem_sh;
         root_in  = {root_ff[RB-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_BITS'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign result.done = done_ff;
   assign result.root = root_ff;

endmodule

// ===== rtl/core/triangle_perimeter_max_finder.sv =====
// top level: point table, edge arithmetic and running maximum of triangle perimeters
//
// channel  dir  tdata                                    tuser   tlast
// req_*    in   slot, x, y, z, corner a, b, c (64 bits)  action  final_triangle
// rsp_*    out  number, distinct, perimeter, best (72)   -       set_done
//
// a point is written to the table when its transfer is taken; a triangle is worked
// through in steps: three table reads, then per edge three squares and one root,
// the root unit producing one root bit per cycle
// the table is not cleared by reset; counters and the maximum are
// results wait in an output register while the next item is taken; a new
// result waits while the previous one is still stalled
module triangle_perimeter_max_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // slot, x, y, z, corner a, corner b, corner c
   input  logic        req_tuser,   // action
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // number, distinct, perimeter, best number, best sum, pad
   output logic        rsp_tlast
);

   localparam int CB = tpm_pkg::COORD_BITS;
   localparam int SB = tpm_pkg::SLOT_BITS;
   localparam int PB = tpm_pkg::PT_BITS;

   tpm_pkg::state_type state_ff, state_in;

   logic [PB-1:0] point_mem [tpm_pkg::POINT_SLOTS];
   logic [PB-1:0] rd_data_ff;
   logic          rd_ok_ff, rd_ok_in;
   logic [SB-1:0] rd_addr;
   logic [3:0]    rd_corner;

   logic [3:0] corner_a_ff, corner_a_in, corner_b_ff, corner_b_in, corner_c_ff, corner_c_in;
   logic       final_ff, final_in;
   logic [PB-1:0] pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;
   logic [1:0] edge_ff, edge_in, axis_ff, axis_in;
   logic [tpm_pkg::SQ_BITS-1:0]   sq_ff, sq_in;
   logic [tpm_pkg::ACC_BITS-1:0]  acc_ff, acc_in;
   logic [tpm_pkg::PSUM_BITS-1:0] per_acc_ff, per_acc_in;

   logic [tpm_pkg::NUM_BITS-1:0] tri_cnt_ff, tri_cnt_in, best_num_ff, best_num_in;
   logic [tpm_pkg::PER_BITS-1:0] best_sum_ff, best_sum_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic          accept, pt_wr;
   logic [3:0]    slot_f;
   logic [PB-1:0] pt_word;
   logic [PB-1:0] rd_point;

   logic [PB-1:0] p_sel, q_sel;
   logic [CB-1:0] p_c, q_c, mag;
   logic [CB:0]   diff;
   logic [tpm_pkg::SQ_BITS-1:0] sq_prod;

   logic                          root_start;
   logic [tpm_pkg::RAD_BITS-1:0]  radicand;
   tpm_pkg::root_res_type         root_res;

   logic [tpm_pkg::PER_BITS-1:0] per_sat, new_best_sum;
   logic [tpm_pkg::NUM_BITS-1:0] new_best_num;
   logic                         distinct, better, out_free;

   assign accept  = req_tvalid && req_tready;
   assign slot_f  = req_tdata[3:0];
   assign pt_word = {req_tdata[36 +: CB], req_tdata[20 +: CB], req_tdata[4 +: CB]};
   assign pt_wr   = accept && (req_tuser == tpm_pkg::ACT_POINT)
                    && (32'(slot_f) < 32'(tpm_pkg::POINT_SLOTS));

   // table read address by fetch phase
   always_comb begin
      unique case (state_ff)
         tpm_pkg::S_FETCH_A: rd_corner = corner_a_ff;
         tpm_pkg::S_FETCH_B: rd_corner = corner_b_ff;
         default:            rd_corner = corner_c_ff;
      endcase
   end
   assign rd_addr  = SB'(rd_corner);
   assign rd_ok_in = 32'(rd_corner) < 32'(tpm_pkg::POINT_SLOTS);
   assign rd_point = rd_ok_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (pt_wr) begin
         point_mem[SB'(slot_f)] <= pt_word;
      end
      rd_data_ff <= point_mem[rd_addr];
   end

   // edge operands and one squared coordinate difference
   always_comb begin
      unique case (edge_ff)
         2'd0:    begin p_sel = pa_ff; q_sel = pb_ff; end
         2'd1:    begin p_sel = pa_ff; q_sel = pc_ff; end
         default: begin p_sel = pc_ff; q_sel = pb_ff; end
      endcase
      unique case (axis_ff)
         2'd0:    begin p_c = p_sel[0 +: CB];      q_c = q_sel[0 +: CB];      end
         2'd1:    begin p_c = p_sel[CB +: CB];     q_c = q_sel[CB +: CB];     end
         default: begin p_c = p_sel[2 * CB +: CB]; q_c = q_sel[2 * CB +: CB]; end
      endcase
   end

   assign diff    = {p_c[CB-1], p_c} - {q_c[CB-1], q_c};
   assign mag     = diff[CB] ? CB'(~diff + 1'b1) : CB'(diff);
   assign sq_prod = {{CB{1'b0}}, mag} * {{CB{1'b0}}, mag};

   assign radicand = {acc_ff, {tpm_pkg::FRAC_SHIFT{1'b0}}};

   tpm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .result   (root_res)
   );

   // perimeter, distinctness and running maximum
   always_comb begin
      if (64'(per_acc_ff) > 64'(tpm_pkg::SUM_MAX)) begin
         per_sat = tpm_pkg::SUM_MAX;
      end else begin
         per_sat = tpm_pkg::PER_BITS'(per_acc_ff);
      end
   end
   assign distinct     = (pa_ff != pb_ff) && (pa_ff != pc_ff) && (pc_ff != pb_ff);
   assign better       = per_sat > best_sum_ff;
   assign new_best_sum = better ? per_sat : best_sum_ff;
   assign new_best_num = better ? tri_cnt_ff : best_num_ff;
   assign out_free     = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in    = state_ff;
      corner_a_in = corner_a_ff;
      corner_b_in = corner_b_ff;
      corner_c_in = corner_c_ff;
      final_in    = final_ff;
      pa_in       = pa_ff;
      pb_in       = pb_ff;
      pc_in       = pc_ff;
      edge_in     = edge_ff;
      axis_in     = axis_ff;
      sq_in       = sq_ff;
      acc_in      = acc_ff;
      per_acc_in  = per_acc_ff;
      tri_cnt_in  = tri_cnt_ff;
      best_num_in = best_num_ff;
      best_sum_in = best_sum_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      root_start  = 1'b0;
      req_tready  = 1'b0;

      unique case (state_ff)
         tpm_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (req_tuser == tpm_pkg::ACT_TRIANGLE)) begin
               corner_a_in = req_tdata[52 +: 4];
               corner_b_in = req_tdata[56 +: 4];
               corner_c_in = req_tdata[60 +: 4];
               final_in    = req_tlast;
               state_in    = tpm_pkg::S_FETCH_A;
            end
         end
         tpm_pkg::S_FETCH_A: begin
            state_in = tpm_pkg::S_FETCH_B;
         end
         tpm_pkg::S_FETCH_B: begin
            pa_in    = rd_point;
            state_in = tpm_pkg::S_FETCH_C;
         end
         tpm_pkg::S_FETCH_C: begin
            pb_in    = rd_point;
            state_in = tpm_pkg::S_LOAD_C;
         end
         tpm_pkg::S_LOAD_C: begin
            pc_in      = rd_point;
            edge_in    = 2'd0;
            axis_in    = 2'd0;
            acc_in     = '0;
            per_acc_in = '0;
            state_in   = tpm_pkg::S_MUL;
         end
         tpm_pkg::S_MUL: begin
            sq_in    = sq_prod;
            state_in = tpm_pkg::S_ACC;
         end
         tpm_pkg::S_ACC: begin
            acc_in = acc_ff + tpm_pkg::ACC_BITS'(sq_ff);
            if (axis_ff == 2'd2) begin
               state_in = tpm_pkg::S_ROOT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = tpm_pkg::S_MUL;
            end
         end
         tpm_pkg::S_ROOT: begin
            root_start = 1'b1;
            state_in   = tpm_pkg::S_WAIT;
         end
         tpm_pkg::S_WAIT: begin
            if (root_res.done) begin
               per_acc_in = per_acc_ff + tpm_pkg::PSUM_BITS'(root_res.root);
               if (edge_ff == 2'd2) begin
                  state_in = tpm_pkg::S_FINISH;
               end else begin
                  edge_in  = edge_ff + 2'd1;
                  axis_in  = 2'd0;
                  acc_in   = '0;
                  state_in = tpm_pkg::S_MUL;
               end
            end
         end
         tpm_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, new_best_sum, new_best_num, per_sat, distinct, tri_cnt_ff};
               rsp_last_in  = final_ff;
               if (final_ff) begin
                  tri_cnt_in  = '0;
                  best_num_in = '0;
                  best_sum_in = '0;
               end else begin
                  tri_cnt_in  = tri_cnt_ff + 1'b1;
                  best_num_in = new_best_num;
                  best_sum_in = new_best_sum;
               end
               state_in = tpm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tpm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpm_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         tri_cnt_ff   <= '0;
         best_num_ff  <= '0;
         best_sum_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tri_cnt_ff   <= tri_cnt_in;
         best_num_ff  <= best_num_in;
         best_sum_ff  <= best_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ok_ff    <= rd_ok_in;
      corner_a_ff <= corner_a_in;
      corner_b_ff <= corner_b_in;
      corner_c_ff <= corner_c_in;
      final_ff    <= final_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      pc_ff       <= pc_in;
      edge_ff     <= edge_in;
      axis_ff     <= axis_in;
      sq_ff       <= sq_in;
      acc_ff      <= acc_in;
      per_acc_ff  <= per_acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/tpm_checker.sv =====
// port checks of the triangle perimeter maximum finder, bound to the top level
module tpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        req_tuser,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tlast
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // running maximum never below this perimeter
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[70:44] >= rsp_tdata[35:9])
      else $error("best perimeter below current perimeter");

   // distinct corners give a nonzero perimeter
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[35:9] != 27'd0)
      else $error("distinct triangle with zero perimeter");

   // a triangle transfer starts work, so no transfer follows at once
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("input taken while a triangle is in work");

endmodule

bind triangle_perimeter_max_finder tpm_checker u_tpm_checker (.*);

// ===== sim/triangle_perimeter_max_finder_tb.sv =====
`timescale 1ns / 1ps
// testbench for the triangle perimeter maximum finder, checked against a predictor
module triangle_perimeter_max_finder_tb;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 200;

   typedef logic signed [tpm_pkg::COORD_BITS-1:0] coord_type;
   typedef logic [63:0] wide_type;

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct {
      logic [tpm_pkg::NUM_BITS-1:0] number;
      logic                         distinct;
      logic [tpm_pkg::PER_BITS-1:0] perimeter;
      logic [tpm_pkg::NUM_BITS-1:0] best_number;
      logic [tpm_pkg::PER_BITS-1:0] best_perimeter;
      logic                         set_done;
   } tri_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;

   point_type                    point_store [tpm_pkg::POINT_SLOTS];
   logic [tpm_pkg::NUM_BITS-1:0] tri_count      = '0;
   logic [tpm_pkg::NUM_BITS-1:0] lead_number    = '0;
   logic [tpm_pkg::PER_BITS-1:0] lead_perimeter = '0;
   tri_result_type               expected_results [$];
   int                           errors       = 0;
   int                           snd_idle_pct = 25;
   int                           rcv_idle_pct = 86;
   int                           quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   triangle_perimeter_max_finder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic wide_type floor_root(wide_type v);
      wide_type r;
      wide_type cand;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         cand = r | (wide_type'(1) << i);
         if (cand * cand <= v) r = cand;
      end
      return r;
   endfunction

   function automatic wide_type edge_length(point_type p, point_type q);
      longint   dx;
      longint   dy;
      longint   dz;
      wide_type sq;
      dx = longint'(p.x) - longint'(q.x);
      dy = longint'(p.y) - longint'(q.y);
      dz = longint'(p.z) - longint'(q.z);
      sq = dx * dx + dy * dy + dz * dz;
      return floor_root(sq << 16);
   endfunction

   function automatic logic same_point(point_type p, point_type q);
      return p.x == q.x && p.y == q.y && p.z == q.z;
   endfunction

   function automatic tri_result_type predict_triangle(logic [3:0] ia, logic [3:0] ib,
                                                       logic [3:0] ic, logic last);
      tri_result_type r;
      point_type      pa;
      point_type      pb;
      point_type      pc;
      wide_type       per;
      pa  = point_store[ia];
      pb  = point_store[ib];
      pc  = point_store[ic];
      per = edge_length(pa, pb) + edge_length(pa, pc) + edge_length(pc, pb);
      if (per > tpm_pkg::SUM_MAX) per = tpm_pkg::SUM_MAX;
      if (per[tpm_pkg::PER_BITS-1:0] > lead_perimeter) begin
         lead_perimeter = per[tpm_pkg::PER_BITS-1:0];
         lead_number    = tri_count;
      end
      r.number         = tri_count;
      r.distinct       = !same_point(pa, pb) && !same_point(pa, pc) && !same_point(pc, pb);
      r.perimeter      = per[tpm_pkg::PER_BITS-1:0];
      r.best_number    = lead_number;
      r.best_perimeter = lead_perimeter;
      r.set_done       = last;
      tri_count        = tri_count + 1'b1;
      if (last) begin
         tri_count      = '0;
         lead_number    = '0;
         lead_perimeter = '0;
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // prediction on each request transfer, checking on each result transfer
   always @(posedge clock) begin
      tri_result_type got;
      tri_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.number         = rsp_tdata[7:0];
            got.distinct       = rsp_tdata[8];
            got.perimeter      = rsp_tdata[35:9];
            got.best_number    = rsp_tdata[43:36];
            got.best_perimeter = rsp_tdata[70:44];
            got.set_done       = rsp_tlast;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual number %0d perimeter %0d",
                        $time, got.number, got.perimeter);
               errors++;
            end else begin
               want = expected_results.pop_front();
               check_field("triangle_number", want.number, got.number);
               check_field("distinct_corners", want.distinct, got.distinct);
               check_field("perimeter", want.perimeter, got.perimeter);
               check_field("best_number", want.best_number, got.best_number);
               check_field("best_perimeter", want.best_perimeter, got.best_perimeter);
               check_field("set_done", want.set_done, got.set_done);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == tpm_pkg::ACT_POINT) begin
               point_store[req_tdata[3:0]].x = req_tdata[19:4];
               point_store[req_tdata[3:0]].y = req_tdata[35:20];
               point_store[req_tdata[3:0]].z = req_tdata[51:36];
            end else begin
               expected_results.push_back(predict_triangle(req_tdata[55:52], req_tdata[59:56],
                                                           req_tdata[63:60], req_tlast));
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("triangle_perimeter_max_finder_tb: FAIL");
         $finish;
      end
   end

   task automatic send_item(logic action, logic [3:0] slot, coord_type x, coord_type y,
                            coord_type z, logic [3:0] ca, logic [3:0] cb, logic [3:0] cc,
                            logic last);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tlast  <= last;
      req_tdata  <= {cc, cb, ca, z, y, x, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_point(int slot, int x, int y, int z);
      send_item(tpm_pkg::ACT_POINT, 4'(slot), coord_type'(x), coord_type'(y), coord_type'(z),
                4'($urandom), 4'($urandom), 4'($urandom), 1'($urandom));
   endtask

   task automatic send_triangle(int a, int b, int c, logic last);
      send_item(tpm_pkg::ACT_TRIANGLE, 4'($urandom), coord_type'($urandom),
                coord_type'($urandom), coord_type'($urandom), 4'(a), 4'(b), 4'(c), last);
   endtask

   function automatic int pick_coord();
      int sel;
      sel = $urandom_range(9);
      if (sel < 5) return int'(coord_type'($urandom));
      if (sel < 8) return int'($urandom_range(8)) - 4;
      case ($urandom_range(2))
         0: return -32768;
         1: return 32767;
         default: return 0;
      endcase
   endfunction

   task automatic send_random_item();
      int src;
      int a;
      int b;
      int c;
      if ($urandom_range(99) < 40) begin
         if ($urandom_range(9) == 0) begin
            src = $urandom_range(tpm_pkg::POINT_SLOTS - 1);
            write_point($urandom_range(tpm_pkg::POINT_SLOTS - 1), int'(point_store[src].x),
                        int'(point_store[src].y), int'(point_store[src].z));
         end else begin
            write_point($urandom_range(tpm_pkg::POINT_SLOTS - 1), pick_coord(), pick_coord(),
                        pick_coord());
         end
      end else begin
         a = $urandom_range(tpm_pkg::POINT_SLOTS - 1);
         b = $urandom_range(tpm_pkg::POINT_SLOTS - 1);
         c = $urandom_range(tpm_pkg::POINT_SLOTS - 1);
         if ($urandom_range(4) == 0) b = a;
         if ($urandom_range(9) == 0) c = b;
         send_triangle(a, b, c, $urandom_range(29) == 0);
      end
   endtask

   // every slot written before any read, extreme coordinates and repeated corners
   task automatic test_extreme_points();
      write_point(0, 0, 0, 0);
      write_point(1, 32767, 32767, 32767);
      write_point(2, -32768, -32768, -32768);
      write_point(3, 32767, -32768, 0);
      write_point(4, 0, 0, 0);
      write_point(5, 3, 4, 0);
      write_point(6, 0, 0, 12);
      write_point(7, -1, -1, -1);
      for (int s = 8; s < tpm_pkg::POINT_SLOTS - 1; s++)
         write_point(s, pick_coord(), pick_coord(), pick_coord());
      write_point(tpm_pkg::POINT_SLOTS - 1, -32768, 32767, -32768);
      send_triangle(1, 2, 3, 1'b0);
      send_triangle(0, 4, 5, 1'b0);
      send_triangle(5, 5, 5, 1'b0);
      send_triangle(15, 0, 14, 1'b1);
   endtask

   // equal perimeters keep the first leader; a set restarts after its last triangle
   task automatic test_tie_and_restart();
      send_triangle(5, 6, 7, 1'b0);
      send_triangle(5, 6, 7, 1'b0);
      send_triangle(7, 5, 6, 1'b0);
      send_triangle(1, 2, 15, 1'b0);
      send_triangle(0, 0, 4, 1'b1);
      send_triangle(0, 4, 0, 1'b0);
      send_triangle(5, 6, 7, 1'b1);
   endtask

   // one set longer than the triangle number range
   task automatic test_counter_wrap();
      repeat (300)
         send_triangle($urandom_range(tpm_pkg::POINT_SLOTS - 1),
                       $urandom_range(tpm_pkg::POINT_SLOTS - 1),
                       $urandom_range(tpm_pkg::POINT_SLOTS - 1), 1'b0);
      send_triangle(1, 2, 3, 1'b1);
   endtask

   task automatic test_random(int snd_pct, int rcv_pct, int count);
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      repeat (count) send_random_item();
   endtask

   task automatic finish_run();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("triangle_perimeter_max_finder_tb: PASS");
      else
         $display("triangle_perimeter_max_finder_tb: FAIL");
      $finish;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_extreme_points();
      test_tie_and_restart();
      test_counter_wrap();
      test_random(25, 86, 325);
      test_random(86, 25, 325);
      test_random(0, 0, 325);
      finish_run();
   end

endmodule

// ===== files.f =====
rtl/core/tpm_pkg.sv
rtl/core/tpm_sqrt.sv
rtl/core/triangle_perimeter_max_finder.sv
rtl/core/tpm_checker.sv
sim/triangle_perimeter_max_finder_tb.sv
